FILE: sv/tnsns_pkg.sv
// Shared types and constants for the tree node store with nearest search.
// Holds the request and result payloads, operation and status codes, and sizes.
// No dependencies.
package tnsns_pkg;

	// Table size and the widths that follow from it.
	localparam int MAX_NODES = 1024;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = IDX_W + 1;

	// Coordinate, cost and distance widths.
	localparam int COORD_W = 16;
	localparam int COST_W  = 32;
	localparam int DIST_W  = 33;
	localparam int THR_W   = 15;

	// Parent code stored for the root.
	localparam logic [CNT_W-1:0] NO_PARENT = '1;

	// Configuration port sizes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REACH_THR = 3'd4;

	typedef enum logic [1:0] {
		OP_NEAREST = 2'd0,
		OP_ADD     = 2'd1,
		OP_RELINK  = 2'd2,
		OP_RESTART = 2'd3
	} tnsns_op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_BAD_INDEX = 2'd2,
		STS_EMPTY     = 2'd3
	} tnsns_status_t;

	// Request payload.
	typedef struct packed {
		tnsns_op_t                 op;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [9:0]                node_index;
		logic [9:0]                parent_index;
		logic [COST_W-1:0]         path_cost;
	} tnsns_req_t;

	// Result payload.
	typedef struct packed {
		tnsns_status_t     status;
		logic [9:0]        found_index;
		logic [DIST_W-1:0] squared_distance;
		logic              goal_reached;
	} tnsns_rsp_t;

	// Write request into the node memories.
	typedef struct packed {
		logic                      pos_we;
		logic                      link_we;
		logic [IDX_W-1:0]          addr;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [CNT_W-1:0]          parent;
		logic [COST_W-1:0]         cost;
	} tnsns_wr_t;

	// Request into the distance pipeline.
	typedef struct packed {
		logic                      valid;
		logic                      goal;
		logic                      last;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
	} tnsns_dreq_t;

	// Result out of the distance pipeline.
	typedef struct packed {
		logic              valid;
		logic              goal;
		logic              last;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] sq_dist;
	} tnsns_drsp_t;

endpackage

FILE: sv/tnsns_node_ram.sv
// Node memories: position memory (x, y) with a registered read port, and the
// link memory (parent, cost). Uses tnsns_pkg.
module tnsns_node_ram import tnsns_pkg::*; (
	input  logic                      clk,
	input  tnsns_wr_t                 wr,
	input  logic                      rd_en,
	input  logic [IDX_W-1:0]          rd_addr,
	output logic signed [COORD_W-1:0] rd_x,
	output logic signed [COORD_W-1:0] rd_y
);

	logic [2*COORD_W-1:0]     pos_mem [MAX_NODES];
	logic [CNT_W+COST_W-1:0]  link_mem [MAX_NODES];
	logic [2*COORD_W-1:0]     rd_q;

	// Position memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr.pos_we) begin
			pos_mem[wr.addr] <= {wr.x, wr.y};
		end
		if (rd_en) begin
			rd_q <= pos_mem[rd_addr];
		end
	end

	// Link memory: parent index and path cost of each node.
	always_ff @(posedge clk) begin
		if (wr.link_we) begin
			link_mem[wr.addr] <= {wr.parent, wr.cost};
		end
	end

	assign rd_x = rd_q[2*COORD_W-1:COORD_W];
	assign rd_y = rd_q[COORD_W-1:0];

endmodule

FILE: sv/tnsns_dist.sv
// Three-stage squared Euclidean distance pipeline with a pass-through tag.
// Stage 1 absolute differences, stage 2 squares, stage 3 sum. Uses tnsns_pkg.
module tnsns_dist import tnsns_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tnsns_dreq_t dreq,
	output tnsns_drsp_t drsp
);

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W:0]        adx, ady;

	logic                    valid_s1, valid_s2, valid_s3;
	logic                    goal_s1, goal_s2, goal_s3;
	logic                    last_s1, last_s2, last_s3;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3;
	logic [COORD_W-1:0]      adx_s1, ady_s1;
	logic [2*COORD_W-1:0]    sqx_s2, sqy_s2;
	logic [DIST_W-1:0]       dist_s3;

	// Differences on one extra bit; the magnitude always fits in 16 bits.
	always_comb begin
		dx  = {dreq.ax[COORD_W-1], dreq.ax} - {dreq.bx[COORD_W-1], dreq.bx};
		dy  = {dreq.ay[COORD_W-1], dreq.ay} - {dreq.by[COORD_W-1], dreq.by};
		adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
		ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= dreq.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Data path of the stages.
	always_ff @(posedge clk) begin
		goal_s1 <= dreq.goal;
		last_s1 <= dreq.last;
		idx_s1  <= dreq.idx;
		adx_s1  <= adx[COORD_W-1:0];
		ady_s1  <= ady[COORD_W-1:0];

		goal_s2 <= goal_s1;
		last_s2 <= last_s1;
		idx_s2  <= idx_s1;
		sqx_s2  <= adx_s1 * adx_s1;
		sqy_s2  <= ady_s1 * ady_s1;

		goal_s3 <= goal_s2;
		last_s3 <= last_s2;
		idx_s3  <= idx_s2;
		dist_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
	end

	assign drsp.valid   = valid_s3;
	assign drsp.goal    = goal_s3;
	assign drsp.last    = last_s3;
	assign drsp.idx     = idx_s3;
	assign drsp.sq_dist = dist_s3;

endmodule

FILE: sv/tree_node_store_nearest_search.sv
// Top level of the tree node store: control sequencer, configuration registers
// and result register. Uses tnsns_pkg, tnsns_node_ram and tnsns_dist.
//
// One request is worked at a time; busy stays high from acceptance until the
// result strobe. A restart, add or relink goes from acceptance through the
// execute step, the goal step and the wait for the goal result to the done
// strobe. A nearest query reads the position memory once per stored node through
// the three-stage distance pipeline and drains it. Every request then runs
// the goal check of the last added node through the same pipeline. The
// result sits on result for the single cycle in which done is high and must
// be taken then; there is no way to hold it off. A new request may be started
// in that same cycle. Configuration writes are always taken (cfg_ready is
// high) and must be done while the block is idle.
module tree_node_store_nearest_search import tnsns_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  tnsns_req_t            req,
	output logic                  done,
	output tnsns_rsp_t            result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_DRAIN = 6'b001000,
		S_GOAL  = 6'b010000,
		S_GWAIT = 6'b100000
	} state_t;

	state_t                    state_q;
	tnsns_req_t                req_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [COORD_W-1:0] last_x_q, last_y_q;
	logic signed [COORD_W-1:0] start_x_q, start_y_q, goal_x_q, goal_y_q;
	logic [THR_W-1:0]          thr_q;
	logic [2*THR_W-1:0]        thr_sq_q;
	logic [IDX_W-1:0]          scan_q;
	logic                      rd_valid_s1, rd_last_s1;
	logic [IDX_W-1:0]          rd_idx_s1;
	tnsns_status_t             res_status_q;
	logic [9:0]                res_found_q;
	logic [DIST_W-1:0]         res_dist_q;
	logic                      done_q;
	logic                      goal_flag_q;

	tnsns_wr_t                 wr;
	tnsns_dreq_t               dreq;
	tnsns_drsp_t               drsp;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	logic                      accept;
	logic                      scan_last;
	logic                      add_full, add_bad, relink_bad;
	logic                      goal_hit;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign scan_last = ({1'b0, scan_q} == (count_q - CNT_W'(1)));

	// Checks of the captured request against the current table size.
	assign add_full   = (count_q >= CNT_W'(MAX_NODES));
	assign add_bad    = ({1'b0, req_q.parent_index} >= count_q);
	assign relink_bad = ({1'b0, req_q.node_index} >= count_q) || add_bad;

	// Memory writes happen only in the execute cycle, never during a scan,
	// so reads and writes of the same entry cannot overlap.
	always_comb begin
		wr         = '0;
		wr.x       = req_q.point_x;
		wr.y       = req_q.point_y;
		wr.parent  = {1'b0, req_q.parent_index};
		wr.cost    = req_q.path_cost;
		wr.addr    = count_q[IDX_W-1:0];
		if (state_q == S_EXEC) begin
			case (req_q.op)
				OP_ADD: begin
					wr.pos_we  = !add_full && !add_bad;
					wr.link_we = !add_full && !add_bad;
				end
				OP_RELINK: begin
					wr.link_we = !relink_bad;
					wr.addr    = req_q.node_index;
				end
				OP_RESTART: begin
					wr.pos_we  = 1'b1;
					wr.link_we = 1'b1;
					wr.addr    = '0;
					wr.x       = start_x_q;
					wr.y       = start_y_q;
					wr.parent  = NO_PARENT;
					wr.cost    = '0;
				end
				default: begin
				end
			endcase
		end
	end

	tnsns_node_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (state_q == S_SCAN),
		.rd_addr (scan_q),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	// The distance pipeline serves the scan and then the goal check.
	always_comb begin
		dreq.valid = rd_valid_s1 || (state_q == S_GOAL);
		dreq.goal  = (state_q == S_GOAL);
		dreq.last  = rd_last_s1;
		dreq.idx   = rd_idx_s1;
		if (state_q == S_GOAL) begin
			dreq.ax = last_x_q;
			dreq.ay = last_y_q;
			dreq.bx = goal_x_q;
			dreq.by = goal_y_q;
		end else begin
			dreq.ax = req_q.point_x;
			dreq.ay = req_q.point_y;
			dreq.bx = rd_x;
			dreq.by = rd_y;
		end
	end

	tnsns_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (dreq),
		.drsp   (drsp)
	);

	assign goal_hit = (count_q != '0) && (drsp.sq_dist < {3'b000, thr_sq_q});

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			goal_x_q  <= '0;
			goal_y_q  <= '0;
			thr_q     <= THR_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_X:   start_x_q <= cfg_data;
				REG_START_Y:   start_y_q <= cfg_data;
				REG_GOAL_X:    goal_x_q  <= cfg_data;
				REG_GOAL_Y:    goal_y_q  <= cfg_data;
				REG_REACH_THR: thr_q     <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and table state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			scan_q      <= '0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_GOAL;
					scan_q  <= '0;
					case (req_q.op)
						OP_NEAREST: begin
							if (count_q != '0) begin
								state_q <= S_SCAN;
							end
						end
						OP_ADD: begin
							if (!add_full && !add_bad) begin
								count_q  <= count_q + CNT_W'(1);
								last_x_q <= req_q.point_x;
								last_y_q <= req_q.point_y;
							end
						end
						OP_RESTART: begin
							count_q  <= CNT_W'(1);
							last_x_q <= start_x_q;
							last_y_q <= start_y_q;
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					rd_valid_s1 <= 1'b1;
					scan_q      <= scan_q + IDX_W'(1);
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (drsp.valid && !drsp.goal && drsp.last) begin
						state_q <= S_GOAL;
					end
				end
				S_GOAL: begin
					state_q <= S_GWAIT;
				end
				S_GWAIT: begin
					if (drsp.valid && drsp.goal) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture, scan tags, best-so-far and result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		rd_idx_s1  <= scan_q;
		rd_last_s1 <= scan_last;
		thr_sq_q   <= thr_q * thr_q;

		if (state_q == S_EXEC) begin
			res_dist_q  <= '0;
			res_found_q <= '0;
			case (req_q.op)
				OP_NEAREST: begin
					res_status_q <= (count_q == '0) ? STS_EMPTY : STS_OK;
				end
				OP_ADD: begin
					if (add_full) begin
						res_status_q <= STS_FULL;
					end else if (add_bad) begin
						res_status_q <= STS_BAD_INDEX;
					end else begin
						res_status_q <= STS_OK;
						res_found_q  <= 10'(count_q);
					end
				end
				OP_RELINK: begin
					res_status_q <= relink_bad ? STS_BAD_INDEX : STS_OK;
				end
				default: begin
					res_status_q <= STS_OK;
				end
			endcase
		end

		// The first node loads the best; later ones replace it only if strictly nearer.
		if (drsp.valid && !drsp.goal) begin
			if ((drsp.idx == '0) || (drsp.sq_dist < res_dist_q)) begin
				res_dist_q  <= drsp.sq_dist;
				res_found_q <= 10'(drsp.idx);
			end
		end

		if ((state_q == S_GWAIT) && drsp.valid && drsp.goal) begin
			goal_flag_q <= goal_hit;
		end
	end

	assign done                    = done_q;
	assign result.status           = res_status_q;
	assign result.found_index      = res_found_q;
	assign result.squared_distance = res_dist_q;
	assign result.goal_reached     = goal_flag_q;

endmodule
